@@ src/pbd_pkg.sv @@
// Shared types, constants and character tables for the PEM base64 block decoder.
`timescale 1ns / 1ps

package pbd_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [3:0] BEGIN_LEN = 4'd11;
  localparam logic [3:0] END_LEN   = 4'd9;
  localparam logic [7:0] CHAR_LF   = 8'h0A;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_COMPLETED = 2'd1,
    KIND_ABANDONED = 2'd2
  } kind_e;

  typedef struct packed {
    logic        in_block;
    logic        decode_stopped;
    logic        block_has_content;
    logic [3:0]  marker_position;
    logic [1:0]  marker_candidates;  // bit 0 BEGIN, bit 1 END still possible
    logic        skip_line;
    logic [11:0] bit_accumulator;
    logic [2:0]  pending_bits;
  } state_t;

  localparam state_t STATE_RESET = '{
    in_block:          1'b0,
    decode_stopped:    1'b0,
    block_has_content: 1'b0,
    marker_position:   4'd0,
    marker_candidates: 2'b11,
    skip_line:         1'b0,
    bit_accumulator:   12'd0,
    pending_bits:      3'd0
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_res_t;

  function automatic logic [7:0] begin_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4: ch = "-";
      4'd5:    ch = "B";
      4'd6:    ch = "E";
      4'd7:    ch = "G";
      4'd8:    ch = "I";
      4'd9:    ch = "N";
      4'd10:   ch = " ";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] end_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4: ch = "-";
      4'd5:    ch = "E";
      4'd6:    ch = "N";
      4'd7:    ch = "D";
      4'd8:    ch = " ";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Bit 6 flags a valid base64 character; '=' maps to zero.
  function automatic logic [6:0] sextet(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= "A" && c <= "Z") begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= "a" && c <= "z") begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= "0" && c <= "9") begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == "+") begin
      r = {1'b1, 6'd62};
    end else if (c == "/") begin
      r = {1'b1, 6'd63};
    end else if (c == "=") begin
      r = {1'b1, 6'd0};
    end
    return r;
  endfunction

endpackage

@@ src/pbd_if.sv @@
// Valid/ready channel interfaces for text input and decoded results.
`timescale 1ns / 1ps

interface pbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface pbd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       last_of_run;

  modport source (output valid, output kind, output data_byte, output last_of_run,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input last_of_run,
                  output ready);
endinterface

@@ src/pbd_char_step.sv @@
// Next-state and result logic for one text character.
`timescale 1ns / 1ps

module pbd_char_step (
  input  pbd_pkg::state_t    state_i,
  input  logic [7:0]         text_byte_i,
  input  logic               end_of_text_i,
  output pbd_pkg::state_t    state_o,
  output pbd_pkg::step_res_t res_o
);

  always_comb begin
    pbd_pkg::state_t    s;
    pbd_pkg::step_res_t r;
    pbd_pkg::result_t   evt;
    logic               have_evt;
    logic               do_plain;
    logic               eot_abandon;
    logic [1:0]         alive;
    logic [3:0]         pos_n;
    logic [6:0]         sx;
    logic [2:0]         pend_n;

    s           = state_i;
    r           = '0;
    evt         = '0;
    have_evt    = 1'b0;
    do_plain    = 1'b0;
    eot_abandon = 1'b0;
    alive       = 2'b00;
    pos_n       = s.marker_position + 4'd1;
    sx          = pbd_pkg::sextet(text_byte_i);
    pend_n      = s.pending_bits - 3'd2;

    if (text_byte_i == pbd_pkg::CHAR_LF) begin
      // Held-back marker prefix turns into content at line end
      if (!s.skip_line && s.marker_candidates != 2'b00 && s.in_block &&
          s.marker_position != 4'd0) begin
        s.block_has_content = 1'b1;
        s.decode_stopped    = 1'b1;
      end
      s.marker_position   = 4'd0;
      s.marker_candidates = 2'b11;
      s.skip_line         = 1'b0;
    end else if (!s.skip_line) begin
      if (s.marker_candidates == 2'b00) begin
        do_plain = 1'b1;
      end else begin
        alive[0] = s.marker_candidates[0] && (s.marker_position < pbd_pkg::BEGIN_LEN) &&
                   (text_byte_i == pbd_pkg::begin_char(s.marker_position));
        alive[1] = s.marker_candidates[1] && (s.marker_position < pbd_pkg::END_LEN) &&
                   (text_byte_i == pbd_pkg::end_char(s.marker_position));
        if (alive == 2'b00) begin
          if (s.in_block && s.marker_position != 4'd0) begin
            s.block_has_content = 1'b1;
            s.decode_stopped    = 1'b1;
          end
          s.marker_candidates = 2'b00;
          do_plain            = 1'b1;
        end else begin
          s.marker_candidates = alive;
          s.marker_position   = pos_n;
          if (alive[0] && pos_n == pbd_pkg::BEGIN_LEN) begin
            if (s.in_block) begin
              have_evt = 1'b1;
              evt.kind = pbd_pkg::KIND_ABANDONED;
            end
            s.in_block          = 1'b1;
            s.decode_stopped    = 1'b0;
            s.block_has_content = 1'b0;
            s.bit_accumulator   = 12'd0;
            s.pending_bits      = 3'd0;
            s.skip_line         = 1'b1;
          end else if (alive[1] && pos_n == pbd_pkg::END_LEN) begin
            if (s.in_block && s.block_has_content) begin
              have_evt = 1'b1;
              evt.kind = pbd_pkg::KIND_COMPLETED;
            end
            s.in_block          = 1'b0;
            s.decode_stopped    = 1'b0;
            s.block_has_content = 1'b0;
            s.bit_accumulator   = 12'd0;
            s.pending_bits      = 3'd0;
            s.skip_line         = 1'b1;
          end
        end
      end
    end

    if (do_plain && s.in_block) begin
      s.block_has_content = 1'b1;
      if (!s.decode_stopped && !pbd_pkg::is_space(text_byte_i)) begin
        if (!sx[6]) begin
          s.decode_stopped = 1'b1;
        end else begin
          s.bit_accumulator = {s.bit_accumulator[5:0], sx[5:0]};
          if (s.pending_bits != 3'd0) begin
            // 2, 4 or 6 bits were waiting: a byte is complete
            have_evt = 1'b1;
            evt.kind = pbd_pkg::KIND_BYTE;
            case (pend_n)
              3'd0:    evt.data_byte = s.bit_accumulator[7:0];
              3'd2:    evt.data_byte = s.bit_accumulator[9:2];
              default: evt.data_byte = s.bit_accumulator[11:4];
            endcase
            s.pending_bits = pend_n;
          end else begin
            s.pending_bits = 3'd6;
          end
        end
      end
    end

    if (end_of_text_i) begin
      eot_abandon = s.in_block;
      s           = pbd_pkg::STATE_RESET;
    end

    if (have_evt) begin
      r.first = evt;
      if (eot_abandon) begin
        r.second.kind        = pbd_pkg::KIND_ABANDONED;
        r.second.last_of_run = 1'b1;
        r.count              = 2'd2;
      end else begin
        r.first.last_of_run = 1'b1;
        r.count             = 2'd1;
      end
    end else if (eot_abandon) begin
      r.first.kind        = pbd_pkg::KIND_ABANDONED;
      r.first.last_of_run = 1'b1;
      r.count             = 2'd1;
    end

    state_o = s;
    res_o   = r;
  end

endmodule

@@ src/pbd_result_queue.sv @@
// Small result queue: takes up to two results per cycle, hands out one per beat.
`timescale 1ns / 1ps

module pbd_result_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         push_count_i,
  input  pbd_pkg::result_t   push_first_i,
  input  pbd_pkg::result_t   push_second_i,
  output logic               room_o,
  pbd_out_if.source          out_o
);

  pbd_pkg::result_t                   entry_q [pbd_pkg::QueueDepth];
  logic [pbd_pkg::QueuePtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [pbd_pkg::QueuePtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [pbd_pkg::QueueCntW-1:0]      count_q, count_d;
  logic                               pop;
  logic [pbd_pkg::QueuePtrW-1:0]      wr_ptr_next;

  assign pop         = out_o.valid && out_o.ready;
  assign wr_ptr_next = wr_ptr_q + pbd_pkg::QueuePtrW'(1);

  // Room for a worst-case beat of two results
  assign room_o = (count_q <= pbd_pkg::QueueCntW'(pbd_pkg::QueueDepth - 2));

  assign out_o.valid       = (count_q != '0);
  assign out_o.kind        = entry_q[rd_ptr_q].kind;
  assign out_o.data_byte   = entry_q[rd_ptr_q].data_byte;
  assign out_o.last_of_run = entry_q[rd_ptr_q].last_of_run;

  always_comb begin
    wr_ptr_d = wr_ptr_q + pbd_pkg::QueuePtrW'(push_count_i);
    rd_ptr_d = pop ? rd_ptr_q + pbd_pkg::QueuePtrW'(1) : rd_ptr_q;
    count_d  = count_q + pbd_pkg::QueueCntW'(push_count_i)
               - pbd_pkg::QueueCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_count_i != 2'd0) begin
      entry_q[wr_ptr_q] <= push_first_i;
    end
    if (push_count_i == 2'd2) begin
      entry_q[wr_ptr_next] <= push_second_i;
    end
  end

endmodule

@@ src/pem_base64_block_decoder.sv @@
// Top level of the PEM base64 block decoder.
//
//   channel  dir  beat payload                        notes
//   in_i     in   text_byte[7:0], end_of_text         one character per beat
//   out_o    out  kind[1:0], data_byte[7:0], last     0..2 results per input beat
//
// One character is taken per cycle while the queue has room; its results are registered
// into a four-entry queue and leave it one per cycle while out_o is ready.
// in_i.ready drops only while the queue holds more than two results.
// Reset clears the scan state to line start with no block open, and empties the queue.
// A stall on out_o fills the queue and then holds in_i.
`timescale 1ns / 1ps

module pem_base64_block_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  pbd_in_if.sink     in_i,
  pbd_out_if.source  out_o
);

  pbd_pkg::state_t    state_q, state_d;
  pbd_pkg::step_res_t step_res;
  logic               accept;
  logic               room;
  logic [1:0]         push_count;

  assign in_i.ready = room;
  assign accept     = in_i.valid && room;
  assign push_count = accept ? step_res.count : 2'd0;

  pbd_char_step u_step (
    .state_i       (state_q),
    .text_byte_i   (in_i.text_byte),
    .end_of_text_i (in_i.end_of_text),
    .state_o       (state_d),
    .res_o         (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbd_pkg::STATE_RESET;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  pbd_result_queue u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_count_i  (push_count),
    .push_first_i  (step_res.first),
    .push_second_i (step_res.second),
    .room_o        (room),
    .out_o         (out_o)
  );

endmodule
